// File: design/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg: shared types and constants for the packet credit manager
// Holds the item, configuration, state and result types and the code
// values used by the admission logic and the top level.
// ----------------------------------------------------------------------------
package pcm_pkg;

   localparam int COUNT_W = 6;
   localparam int SIZE_W  = 16;
   localparam int POOL_W  = 2;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [1:0] {
      KIND_TX_REQ = 2'd0,
      KIND_RX_REQ = 2'd1,
      KIND_TX_REL = 2'd2,
      KIND_RX_REL = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SRC_NONE     = 2'd0,
      SRC_RESERVED = 2'd1,
      SRC_DATA     = 2'd2,
      SRC_HEAP     = 2'd3
   } source_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SIZE  = 3'd1,
      ST_LIMIT = 3'd2,
      ST_HEAP  = 3'd3,
      ST_UNDER = 3'd4
   } status_type;

   // Release origin codes; any other code is an uncounted heap release.
   localparam logic [1:0] REL_DATA     = 2'd0;
   localparam logic [1:0] REL_RESERVED = 2'd1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TX_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_MAX      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_MAX      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_RES_ROOM = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_RES_ROOM = 3'd5;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] TX_LIMIT_RST    = 6'd32;
   localparam logic [COUNT_W-1:0] RX_LIMIT_RST    = 6'd16;
   localparam logic [SIZE_W-1:0]  TX_MAX_RST      = 16'd1600;
   localparam logic [SIZE_W-1:0]  RX_MAX_RST      = 16'd1600;
   localparam logic [SIZE_W-1:0]  TX_RES_ROOM_RST = 16'd352;
   localparam logic [SIZE_W-1:0]  RX_RES_ROOM_RST = 16'd1600;

   typedef struct packed {
      kind_type            kind;
      logic                is_command;
      logic [SIZE_W-1:0]   head_room;
      logic [SIZE_W-1:0]   tail_room;
      logic [SIZE_W-1:0]   meta_bytes;
      logic                heap_ok;
      logic [1:0]          release_source;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] tx_limit;
      logic [COUNT_W-1:0] rx_limit;
      logic [SIZE_W-1:0]  tx_max_field;
      logic [SIZE_W-1:0]  rx_max_field;
      logic [SIZE_W-1:0]  tx_reserved_room;
      logic [SIZE_W-1:0]  rx_reserved_room;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] tx_in_use;
      logic [COUNT_W-1:0] rx_in_use;
      logic               tx_paused;
      logic [POOL_W-1:0]  tx_reserved_free;
      logic [POOL_W-1:0]  rx_reserved_free;
   } state_type;

   typedef struct packed {
      logic       granted;
      source_type source;
      status_type status;
      logic       notify;
      logic       paused;
   } rsp_type;

endpackage

// File: design/pcm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_engine: admission decision for one item
// Combinational: from the registered item, the configuration and the
// current credit state it forms the result and the next credit state.
// ----------------------------------------------------------------------------
module pcm_engine #(
   parameter int TX_CMD_BLOCKS = 2,
   parameter int RX_CMD_BLOCKS = 2
) (
   input  pcm_pkg::req_type   req,
   input  pcm_pkg::cfg_type   cfg,
   input  pcm_pkg::state_type cur,
   output pcm_pkg::state_type nxt,
   output pcm_pkg::rsp_type   rsp
);
   import pcm_pkg::*;

   localparam logic [POOL_W-1:0] TX_CAP = POOL_W'(TX_CMD_BLOCKS);
   localparam logic [POOL_W-1:0] RX_CAP = POOL_W'(RX_CMD_BLOCKS);

   logic                tx_fit;
   logic                rx_fit;
   logic [SIZE_W+1:0]   tx_sum;
   logic [SIZE_W:0]     rx_sum;
   logic                tx_res_fit;
   logic                rx_res_fit;
   logic                is_tx;

   assign tx_fit = (req.head_room <= cfg.tx_max_field) &&
                   (req.tail_room <= cfg.tx_max_field) &&
                   (req.meta_bytes <= cfg.tx_max_field);
   assign rx_fit = (req.tail_room <= cfg.rx_max_field) &&
                   (req.meta_bytes <= cfg.rx_max_field);

   assign tx_sum = {2'b00, req.head_room} + {2'b00, req.tail_room} +
                   {2'b00, req.meta_bytes};
   assign rx_sum = {1'b0, req.tail_room} + {1'b0, req.meta_bytes};

   assign tx_res_fit = tx_sum <= {2'b00, cfg.tx_reserved_room};
   assign rx_res_fit = rx_sum <= {1'b0, cfg.rx_reserved_room};
   assign is_tx      = (req.kind == KIND_TX_REL);

   always_comb begin
      nxt         = cur;
      rsp.granted = 1'b0;
      rsp.source  = SRC_NONE;
      rsp.status  = ST_OK;
      rsp.notify  = 1'b0;
      rsp.paused  = 1'b0;

      unique case (req.kind)
         KIND_TX_REQ: begin
            if (!tx_fit) begin
               rsp.status = ST_SIZE;
            end else if (req.is_command && (cur.tx_reserved_free != '0) && tx_res_fit) begin
               nxt.tx_reserved_free = cur.tx_reserved_free - POOL_W'(1);
               rsp.granted          = 1'b1;
               rsp.source           = SRC_RESERVED;
            end else if (cur.tx_in_use >= cfg.tx_limit) begin
               rsp.status = ST_LIMIT;
            end else if (!req.heap_ok) begin
               rsp.status = ST_HEAP;
            end else begin
               // The count is below the limit here, so it cannot wrap.
               nxt.tx_in_use = cur.tx_in_use + COUNT_W'(1);
               rsp.granted   = 1'b1;
               rsp.source    = SRC_DATA;
               if ((nxt.tx_in_use >= cfg.tx_limit) && !cur.tx_paused) begin
                  nxt.tx_paused = 1'b1;
                  rsp.notify    = 1'b1;
               end
            end
         end
         KIND_RX_REQ: begin
            if (!rx_fit) begin
               rsp.status = ST_SIZE;
            end else if (req.is_command) begin
               if ((cur.rx_reserved_free != '0) && rx_res_fit) begin
                  nxt.rx_reserved_free = cur.rx_reserved_free - POOL_W'(1);
                  rsp.granted          = 1'b1;
                  rsp.source           = SRC_RESERVED;
               end else if (req.heap_ok) begin
                  rsp.granted = 1'b1;
                  rsp.source  = SRC_HEAP;
               end else begin
                  rsp.status = ST_HEAP;
               end
            end else if (cur.rx_in_use >= cfg.rx_limit) begin
               rsp.status = ST_LIMIT;
            end else if (!req.heap_ok) begin
               rsp.status = ST_HEAP;
            end else begin
               nxt.rx_in_use = cur.rx_in_use + COUNT_W'(1);
               rsp.granted   = 1'b1;
               rsp.source    = SRC_DATA;
            end
         end
         KIND_TX_REL, KIND_RX_REL: begin
            unique case (req.release_source)
               REL_DATA: begin
                  if (is_tx) begin
                     if (cur.tx_in_use == '0) begin
                        rsp.status = ST_UNDER;
                     end else begin
                        nxt.tx_in_use = cur.tx_in_use - COUNT_W'(1);
                     end
                     // Resume once the count is below the limit minus two.
                     if ((({1'b0, nxt.tx_in_use} + 7'd2) < {1'b0, cfg.tx_limit}) &&
                         cur.tx_paused) begin
                        nxt.tx_paused = 1'b0;
                        rsp.notify    = 1'b1;
                     end
                  end else begin
                     if (cur.rx_in_use == '0) begin
                        rsp.status = ST_UNDER;
                     end else begin
                        nxt.rx_in_use = cur.rx_in_use - COUNT_W'(1);
                     end
                  end
               end
               REL_RESERVED: begin
                  if (is_tx) begin
                     if (cur.tx_reserved_free >= TX_CAP) begin
                        rsp.status = ST_UNDER;
                     end else begin
                        nxt.tx_reserved_free = cur.tx_reserved_free + POOL_W'(1);
                     end
                  end else begin
                     if (cur.rx_reserved_free >= RX_CAP) begin
                        rsp.status = ST_UNDER;
                     end else begin
                        nxt.rx_reserved_free = cur.rx_reserved_free + POOL_W'(1);
                     end
                  end
               end
               default: begin
                  // Heap releases are not counted and change nothing.
               end
            endcase
         end
         default: begin
         end
      endcase

      rsp.paused = nxt.tx_paused;
   end

endmodule

// File: design/packet_credit_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_credit_manager: credit-based admission of packet buffer requests
// Grants and releases transmit and receive buffers against credit limits,
// with small reserved pools for command traffic and transmit pause control.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register, and its result is registered
// when the result register is empty or being emptied. Throughput: one item
// per cycle while results are taken; the credit state is updated in the same
// cycle that the item moves from the input register to the result register.
// Reset: synchronous and active high; it empties both registers, restores
// all configuration registers to their defaults and returns every credit
// count and reserved pool to its initial value.
// ----------------------------------------------------------------------------
module packet_credit_manager #(
   parameter int TX_CMD_BLOCKS = 2,
   parameter int RX_CMD_BLOCKS = 2
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Bits from the lowest up: head_room[15:0], tail_room[15:0],
   // meta_bytes[15:0], heap_ok, release_source[1:0], five zero bits.
   input  logic [55:0]                   req_tdata,
   // Bits from the lowest up: kind[1:0], is_command.
   input  logic [2:0]                    req_tuser,

   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Bits from the lowest up: granted, source[1:0], status[2:0], notify,
   // paused.
   output logic [7:0]                    rsp_tdata,

   input  logic                          csr_we,
   input  logic [pcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcm_pkg::SIZE_W-1:0]    csr_wdata
);
   import pcm_pkg::*;

   // Input register: holds the item until the result register can take
   // its result.
   req_type   req_ff;
   logic      req_valid_ff;
   req_type   req_in;

   // Result register.
   rsp_type   rsp_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_in;

   // Credit state and configuration.
   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;

   logic      advance;

   // The item in the input register moves on when the result register is
   // empty or its result is taken in this same cycle. The input register
   // accepts a new item when it is empty or being emptied.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_comb begin
      req_in.kind           = kind_type'(req_tuser[1:0]);
      req_in.is_command     = req_tuser[2];
      req_in.head_room      = req_tdata[15:0];
      req_in.tail_room      = req_tdata[31:16];
      req_in.meta_bytes     = req_tdata[47:32];
      req_in.heap_ok        = req_tdata[48];
      req_in.release_source = req_tdata[50:49];
   end

   pcm_engine #(
      .TX_CMD_BLOCKS (TX_CMD_BLOCKS),
      .RX_CMD_BLOCKS (RX_CMD_BLOCKS)
   ) u_engine (
      .req (req_ff),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_ff <= req_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Credit state changes only when an item is decided.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.tx_in_use        <= '0;
         state_ff.rx_in_use        <= '0;
         state_ff.tx_paused        <= 1'b0;
         state_ff.tx_reserved_free <= POOL_W'(TX_CMD_BLOCKS);
         state_ff.rx_reserved_free <= POOL_W'(RX_CMD_BLOCKS);
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Configuration writes; indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tx_limit         <= TX_LIMIT_RST;
         cfg_ff.rx_limit         <= RX_LIMIT_RST;
         cfg_ff.tx_max_field     <= TX_MAX_RST;
         cfg_ff.rx_max_field     <= RX_MAX_RST;
         cfg_ff.tx_reserved_room <= TX_RES_ROOM_RST;
         cfg_ff.rx_reserved_room <= RX_RES_ROOM_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TX_LIMIT:    cfg_ff.tx_limit         <= csr_wdata[COUNT_W-1:0];
            CSR_RX_LIMIT:    cfg_ff.rx_limit         <= csr_wdata[COUNT_W-1:0];
            CSR_TX_MAX:      cfg_ff.tx_max_field     <= csr_wdata;
            CSR_RX_MAX:      cfg_ff.rx_max_field     <= csr_wdata;
            CSR_TX_RES_ROOM: cfg_ff.tx_reserved_room <= csr_wdata;
            CSR_RX_RES_ROOM: cfg_ff.rx_reserved_room <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.paused, rsp_ff.notify, rsp_ff.status,
                        rsp_ff.source, rsp_ff.granted};

endmodule
